// ----- src/bsed_pkg.sv -----
// ----------------------------------------------------------------------------
// bsed_pkg: shared types and constants of the backslash escape decoder
// Phase codes, character codes and the result bundle passed front to back.
// ----------------------------------------------------------------------------
package bsed_pkg;

   localparam int MaxResults = 3;

   // decoder phases
   localparam logic [2:0] PH_PLAIN = 3'd0;
   localparam logic [2:0] PH_ESC   = 3'd1;
   localparam logic [2:0] PH_OCT   = 3'd2;
   localparam logic [2:0] PH_HEX   = 3'd3;
   localparam logic [2:0] PH_HALT  = 3'd4;

   // characters
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_A_LOWER   = 8'h61;
   localparam logic [7:0] CH_B_LOWER   = 8'h62;
   localparam logic [7:0] CH_C_LOWER   = 8'h63;
   localparam logic [7:0] CH_E_LOWER   = 8'h65;
   localparam logic [7:0] CH_F_LOWER   = 8'h66;
   localparam logic [7:0] CH_N_LOWER   = 8'h6E;
   localparam logic [7:0] CH_R_LOWER   = 8'h72;
   localparam logic [7:0] CH_T_LOWER   = 8'h74;
   localparam logic [7:0] CH_V_LOWER   = 8'h76;
   localparam logic [7:0] CH_X_LOWER   = 8'h78;

   // control codes produced by escapes
   localparam logic [7:0] CC_BEL = 8'h07;
   localparam logic [7:0] CC_BS  = 8'h08;
   localparam logic [7:0] CC_HT  = 8'h09;
   localparam logic [7:0] CC_LF  = 8'h0A;
   localparam logic [7:0] CC_VT  = 8'h0B;
   localparam logic [7:0] CC_FF  = 8'h0C;
   localparam logic [7:0] CC_CR  = 8'h0D;
   localparam logic [7:0] CC_ESC = 8'h1B;

   // all results caused by one input item
   typedef struct packed {
      logic [MaxResults-1:0][7:0] data;
      logic [1:0]                 count;     // 0 to 3 results
      logic                       byte_valid; // 0 only for an empty end marker
      logic                       last;
   } bsed_bundle_type;

   // returns {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ----- src/bsed_front.sv -----
// ----------------------------------------------------------------------------
// bsed_front: input side of the escape decoder
// Accepts bytes, runs the escape state machine and pushes one result bundle
// per item into the queue.
// ----------------------------------------------------------------------------
module bsed_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic                     csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     req_tlast,
   input  logic                     q_full,
   output logic                     q_push,
   output bsed_pkg::bsed_bundle_type q_wr_data
);
   import bsed_pkg::*;

   logic       enabled_ff;
   logic [2:0] phase_ff, phase_in;
   logic [8:0] acc_ff, acc_in;
   logic [1:0] cnt_ff, cnt_in;

   bsed_bundle_type bnd;
   logic [1:0]      n;
   logic            do_plain;
   logic [4:0]      hx;
   logic [7:0]      c;
   logic            is_oct;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign q_wr_data  = bnd;
   assign c          = req_tdata;
   assign hx         = hex_decode(req_tdata);
   assign is_oct     = (c >= CH_ZERO) && (c <= CH_SEVEN);

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      bnd      = '0;
      bnd.byte_valid = 1'b1;
      bnd.last = req_tlast;
      n        = 2'd0;
      do_plain = 1'b0;

      if (!enabled_ff) begin
         phase_in = PH_PLAIN;
         acc_in   = '0;
         cnt_in   = '0;
         bnd.data[n] = c;
         n = n + 2'd1;
      end else begin
         unique case (phase_ff)
            PH_ESC: begin
               phase_in = PH_PLAIN;
               unique case (c)
                  CH_A_LOWER: begin bnd.data[n] = CC_BEL; n = n + 2'd1; end
                  CH_B_LOWER: begin bnd.data[n] = CC_BS;  n = n + 2'd1; end
                  CH_E_LOWER: begin bnd.data[n] = CC_ESC; n = n + 2'd1; end
                  CH_F_LOWER: begin bnd.data[n] = CC_FF;  n = n + 2'd1; end
                  CH_N_LOWER: begin bnd.data[n] = CC_LF;  n = n + 2'd1; end
                  CH_R_LOWER: begin bnd.data[n] = CC_CR;  n = n + 2'd1; end
                  CH_T_LOWER: begin bnd.data[n] = CC_HT;  n = n + 2'd1; end
                  CH_V_LOWER: begin bnd.data[n] = CC_VT;  n = n + 2'd1; end
                  CH_BACKSLASH: begin
                     bnd.data[n] = CH_BACKSLASH;
                     n = n + 2'd1;
                  end
                  CH_C_LOWER: phase_in = PH_HALT;
                  CH_ZERO: begin
                     phase_in = PH_OCT;
                     acc_in   = '0;
                     cnt_in   = '0;
                  end
                  CH_X_LOWER: begin
                     phase_in = PH_HEX;
                     acc_in   = '0;
                     cnt_in   = '0;
                  end
                  default: begin
                     // unknown escape keeps its backslash
                     bnd.data[n] = CH_BACKSLASH;
                     n = n + 2'd1;
                     bnd.data[n] = c;
                     n = n + 2'd1;
                  end
               endcase
            end
            PH_OCT: begin
               if (is_oct) begin
                  acc_in = {acc_ff[5:0], c[2:0]};
                  cnt_in = cnt_ff + 2'd1;
                  if (cnt_in == 2'd3) begin
                     bnd.data[n] = acc_in[7:0];
                     n = n + 2'd1;
                     phase_in = PH_PLAIN;
                  end
               end else begin
                  bnd.data[n] = acc_ff[7:0];
                  n = n + 2'd1;
                  do_plain = 1'b1;
               end
            end
            PH_HEX: begin
               if (cnt_ff == 2'd0) begin
                  if (hx[4]) begin
                     acc_in = {5'd0, hx[3:0]};
                     cnt_in = 2'd1;
                  end else begin
                     bnd.data[n] = CH_BACKSLASH;
                     n = n + 2'd1;
                     bnd.data[n] = CH_X_LOWER;
                     n = n + 2'd1;
                     do_plain = 1'b1;
                  end
               end else if (hx[4]) begin
                  bnd.data[n] = {acc_ff[3:0], hx[3:0]};
                  n = n + 2'd1;
                  phase_in = PH_PLAIN;
               end else begin
                  bnd.data[n] = acc_ff[7:0];
                  n = n + 2'd1;
                  do_plain = 1'b1;
               end
            end
            PH_HALT: ;
            default: do_plain = 1'b1;
         endcase
      end

      if (do_plain) begin
         phase_in = PH_PLAIN;
         if (c == CH_BACKSLASH && !req_tlast) begin
            phase_in = PH_ESC;
         end else begin
            bnd.data[n] = c;
            n = n + 2'd1;
         end
      end

      // end of string flushes a pending digit escape
      if (req_tlast) begin
         if (phase_in == PH_OCT) begin
            bnd.data[n] = acc_in[7:0];
            n = n + 2'd1;
         end else if (phase_in == PH_HEX) begin
            if (cnt_in == 2'd0) begin
               bnd.data[n] = CH_BACKSLASH;
               n = n + 2'd1;
               bnd.data[n] = CH_X_LOWER;
               n = n + 2'd1;
            end else begin
               bnd.data[n] = acc_in[7:0];
               n = n + 2'd1;
            end
         end
         if (n == 2'd0) begin
            bnd.byte_valid = 1'b0;
            n = 2'd1;
         end
         phase_in = PH_PLAIN;
         acc_in   = '0;
         cnt_in   = '0;
      end
      bnd.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         phase_ff   <= PH_PLAIN;
         acc_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         if (csr_we) begin
            enabled_ff <= csr_wdata;
         end
         if (q_push) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   // a bundle with no results must not be queued (count 0 means nothing)
   // but items without output and without last simply push nothing visible
endmodule

// ----- src/bsed_queue.sv -----
// ----------------------------------------------------------------------------
// bsed_queue: two-entry bundle queue
// Decouples the escape state machine from the result serializer.
// ----------------------------------------------------------------------------
module bsed_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bsed_pkg::bsed_bundle_type wr_data,
   output logic                     full,
   input  logic                     pop,
   output bsed_pkg::bsed_bundle_type rd_data,
   output logic                     empty
);
   import bsed_pkg::*;

   bsed_bundle_type mem_ff [2];
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      cnt_ff, cnt_in;
   logic            do_push;

   // items that give no result need no slot
   assign do_push = push && (wr_data.count != 2'd0);
   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!do_push && pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("bundle pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("bundle popped from empty queue");
`endif
endmodule

// ----- src/bsed_back.sv -----
// ----------------------------------------------------------------------------
// bsed_back: result serializer
// Takes the head bundle and sends its results one per cycle, while rsp_tready
// does not stall the output, through a registered output stage.
// ----------------------------------------------------------------------------
module bsed_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bsed_pkg::bsed_bundle_type head,
   input  logic                     q_empty,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   import bsed_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] data_ff;
   logic       user_ff;
   logic       last_ff;
   logic       load;
   logic       final_one;

   assign load      = !q_empty && (!valid_ff || rsp_tready);
   assign final_one = (idx_ff == head.count - 2'd1);
   assign q_pop     = load && final_one;
   assign idx_in    = final_one ? 2'd0 : idx_ff + 2'd1;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.data[idx_ff];
         user_ff <= head.byte_valid;
         last_ff <= head.last && final_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("empty end marker without last");
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (idx_ff == 2'd0))
      else $error("serializer index left mid-bundle");
`endif
endmodule

// ----- src/backslash_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// backslash_escape_decoder: echo-style backslash escape decoder
// Decodes one string per run of bytes, expanding backslash escapes.
// ----------------------------------------------------------------------------
// Bytes enter on the req_ stream, one per item, req_tlast on the string's
// final byte. Decoded bytes leave on the rsp_ stream; rsp_tuser is 0 only
// on an empty end marker (a string that produced no bytes), and rsp_tlast
// marks the final result of the string. csr_we/csr_wdata set the escape
// enable; write it only while the block is idle.
// Path: an accepted item is written into a queue entry, and its results
// then pass through the output register. Throughput: one input item per
// cycle while each item yields at most one result and rsp_tready is high;
// an item yielding up to three results sends them one at a time through
// the single-result output register.
// A two-bundle queue sits between the escape state machine and the
// output serializer, so input is still taken while a result waits.
// When rsp_tready is low the output holds, the queue fills and req_tready
// drops once both entries are used.
// Reset clears the escape enable, the decoder phase and the queue.
// ----------------------------------------------------------------------------
module backslash_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,    // escapes_enabled
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] in_byte
   input  logic       req_tlast,    // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_byte
   output logic       rsp_tuser,    // [0] byte_valid
   output logic       rsp_tlast     // out_last
);
   import bsed_pkg::*;

   bsed_bundle_type wr_bundle;
   bsed_bundle_type head;
   logic            q_push;
   logic            q_full;
   logic            q_pop;
   logic            q_empty;

   bsed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wr_data  (wr_bundle)
   );

   bsed_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (wr_bundle),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (head),
      .empty   (q_empty)
   );

   bsed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
